// ===== rtl/ubx_pkg.sv =====
// ----------------------------------------------------------------------------
// ubx_pkg
// Shared constants and the result word type of the frame deframer.
// ----------------------------------------------------------------------------
package ubx_pkg;

  localparam logic [7:0]  SyncOne       = 8'hB5;
  localparam logic [7:0]  SyncTwo       = 8'h62;
  localparam logic [15:0] LenLimitReset = 16'd8192;

  // result kinds
  localparam logic [1:0] KindPayload  = 2'd0;
  localparam logic [1:0] KindGood     = 2'd1;
  localparam logic [1:0] KindBadSum   = 2'd2;
  localparam logic [1:0] KindRejected = 2'd3;

  // phase codes
  localparam logic [3:0] PhHunt1   = 4'd0;
  localparam logic [3:0] PhHunt2   = 4'd1;
  localparam logic [3:0] PhClass   = 4'd2;
  localparam logic [3:0] PhId      = 4'd3;
  localparam logic [3:0] PhLenLo   = 4'd4;
  localparam logic [3:0] PhLenHi   = 4'd5;
  localparam logic [3:0] PhPayload = 4'd6;
  localparam logic [3:0] PhCkA     = 4'd7;
  localparam logic [3:0] PhCkB     = 4'd8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] frame_len;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [15:0] good_count;
    logic [15:0] bad_sum_count;
    logic [15:0] resync_count;
  } result_t;

endpackage

// ===== rtl/ubx_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// ubx_frame_deframer
// Byte-serial deframer: sync hunt, header, payload streaming, 8-bit Fletcher check.
// ----------------------------------------------------------------------------
// A result word is registered into the output word when that word is free, else into the skid word.
// Throughput: one byte per cycle while in_ready_o is high; the per-byte state update is a single pass.
// A two-word output register/skid pair lets bytes keep flowing while one
// result waits; input stalls only when both words are occupied.
// Reset (rst_ni low, asynchronous): hunting, counters zero, limit 8192.
module ubx_frame_deframer #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  msg_class_o,
  output logic [7:0]  msg_id_o,
  output logic [15:0] frame_len_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] byte_index_o,
  output logic [15:0] good_count_o,
  output logic [15:0] bad_sum_count_o,
  output logic [15:0] resync_count_o
);

  logic [15:0] max_len_q;
  logic [3:0]  phase_q, phase_d;
  logic [7:0]  class_q, class_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] len_q, len_d;
  logic [15:0] seen_q, seen_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [7:0]  got_a_q, got_a_d;
  logic        skipped_q, skipped_d;
  logic [COUNT_WIDTH-1:0] good_q, good_d;
  logic [COUNT_WIDTH-1:0] bad_q, bad_d;
  logic [COUNT_WIDTH-1:0] resync_q, resync_d;

  logic                res_valid;
  logic [1:0]          res_kind;
  logic [7:0]          res_pbyte;
  logic [15:0]         res_idx;
  ubx_pkg::result_t    res;
  ubx_pkg::result_t    out_q, skid_q;
  logic                out_valid_q, skid_valid_q;
  logic                in_fire, res_fire, out_free;
  logic [7:0]          sum_a_in, sum_b_in;
  logic [7:0]          base_a, base_b;
  logic [15:0]         seen_inc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign res_fire    = in_fire && res_valid;
  assign out_free    = !out_valid_q || out_ready_i;

  // class byte restarts the running sums
  assign base_a   = (phase_q == ubx_pkg::PhClass) ? 8'd0 : sum_a_q;
  assign base_b   = (phase_q == ubx_pkg::PhClass) ? 8'd0 : sum_b_q;
  assign sum_a_in = base_a + rx_byte_i;
  assign sum_b_in = base_b + sum_a_in;
  assign seen_inc = seen_q + 16'd1;

  always_comb begin
    phase_d   = phase_q;
    class_d   = class_q;
    id_d      = id_q;
    len_d     = len_q;
    seen_d    = seen_q;
    sum_a_d   = sum_a_q;
    sum_b_d   = sum_b_q;
    got_a_d   = got_a_q;
    skipped_d = skipped_q;
    good_d    = good_q;
    bad_d     = bad_q;
    resync_d  = resync_q;
    res_valid = 1'b0;
    res_kind  = ubx_pkg::KindPayload;
    res_pbyte = 8'd0;
    res_idx   = 16'd0;
    unique case (phase_q)
      ubx_pkg::PhHunt2: begin
        if (rx_byte_i == ubx_pkg::SyncTwo) begin
          if (skipped_q) resync_d = resync_q + COUNT_WIDTH'(1);
          skipped_d = 1'b0;
          phase_d   = ubx_pkg::PhClass;
        end else begin
          skipped_d = 1'b1;
          phase_d   = (rx_byte_i == ubx_pkg::SyncOne) ? ubx_pkg::PhHunt2 : ubx_pkg::PhHunt1;
        end
      end
      ubx_pkg::PhClass: begin
        class_d = rx_byte_i;
        sum_a_d = sum_a_in;
        sum_b_d = sum_b_in;
        phase_d = ubx_pkg::PhId;
      end
      ubx_pkg::PhId: begin
        id_d    = rx_byte_i;
        sum_a_d = sum_a_in;
        sum_b_d = sum_b_in;
        phase_d = ubx_pkg::PhLenLo;
      end
      ubx_pkg::PhLenLo: begin
        len_d   = {8'd0, rx_byte_i};
        sum_a_d = sum_a_in;
        sum_b_d = sum_b_in;
        phase_d = ubx_pkg::PhLenHi;
      end
      ubx_pkg::PhLenHi: begin
        len_d   = {rx_byte_i, len_q[7:0]};
        sum_a_d = sum_a_in;
        sum_b_d = sum_b_in;
        seen_d  = 16'd0;
        if (len_d > max_len_q) begin
          resync_d  = resync_q + COUNT_WIDTH'(1);
          skipped_d = 1'b0;
          phase_d   = ubx_pkg::PhHunt1;
          res_valid = 1'b1;
          res_kind  = ubx_pkg::KindRejected;
        end else begin
          phase_d = (len_d == 16'd0) ? ubx_pkg::PhCkA : ubx_pkg::PhPayload;
        end
      end
      ubx_pkg::PhPayload: begin
        sum_a_d   = sum_a_in;
        sum_b_d   = sum_b_in;
        seen_d    = seen_inc;
        if (seen_inc >= len_q) phase_d = ubx_pkg::PhCkA;
        res_valid = 1'b1;
        res_kind  = ubx_pkg::KindPayload;
        res_pbyte = rx_byte_i;
        res_idx   = seen_q;
      end
      ubx_pkg::PhCkA: begin
        got_a_d = rx_byte_i;
        phase_d = ubx_pkg::PhCkB;
      end
      ubx_pkg::PhCkB: begin
        if (got_a_q == sum_a_q && rx_byte_i == sum_b_q) begin
          good_d   = good_q + COUNT_WIDTH'(1);
          res_kind = ubx_pkg::KindGood;
        end else begin
          bad_d    = bad_q + COUNT_WIDTH'(1);
          res_kind = ubx_pkg::KindBadSum;
        end
        skipped_d = 1'b0;
        phase_d   = ubx_pkg::PhHunt1;
        res_valid = 1'b1;
      end
      default: begin
        // first sync hunt, also any unused phase code
        if (rx_byte_i == ubx_pkg::SyncOne) begin
          phase_d = ubx_pkg::PhHunt2;
        end else begin
          skipped_d = 1'b1;
          phase_d   = ubx_pkg::PhHunt1;
        end
      end
    endcase
  end

  always_comb begin
    res.kind          = res_kind;
    res.msg_class     = class_d;
    res.msg_id        = id_d;
    res.frame_len     = len_d;
    res.payload_byte  = res_pbyte;
    res.byte_index    = res_idx;
    res.good_count    = 16'(good_d);
    res.bad_sum_count = 16'(bad_d);
    res.resync_count  = 16'(resync_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= ubx_pkg::LenLimitReset;
      phase_q   <= ubx_pkg::PhHunt1;
      class_q   <= 8'd0;
      id_q      <= 8'd0;
      len_q     <= 16'd0;
      seen_q    <= 16'd0;
      sum_a_q   <= 8'd0;
      sum_b_q   <= 8'd0;
      got_a_q   <= 8'd0;
      skipped_q <= 1'b0;
      good_q    <= '0;
      bad_q     <= '0;
      resync_q  <= '0;
    end else begin
      if (cfg_valid_i) max_len_q <= cfg_data_i;
      if (in_fire) begin
        phase_q   <= phase_d;
        class_q   <= class_d;
        id_q      <= id_d;
        len_q     <= len_d;
        seen_q    <= seen_d;
        sum_a_q   <= sum_a_d;
        sum_b_q   <= sum_b_d;
        got_a_q   <= got_a_d;
        skipped_q <= skipped_d;
        good_q    <= good_d;
        bad_q     <= bad_d;
        resync_q  <= resync_d;
      end
    end
  end

  // output word plus skid word; new words go to the skid only when the
  // output word is held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q  <= skid_valid_q || res_fire;
        skid_valid_q <= 1'b0;
      end else if (res_fire) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (res_fire) out_q <= res;
    end else if (res_fire) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_q.kind;
  assign msg_class_o     = out_q.msg_class;
  assign msg_id_o        = out_q.msg_id;
  assign frame_len_o     = out_q.frame_len;
  assign payload_byte_o  = out_q.payload_byte;
  assign byte_index_o    = out_q.byte_index;
  assign good_count_o    = out_q.good_count;
  assign bad_sum_count_o = out_q.bad_sum_count;
  assign resync_count_o  = out_q.resync_count;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held without output word");

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= ubx_pkg::PhCkB)
    else $error("phase left the legal code range");

  a_payload_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == ubx_pkg::PhPayload) |-> (seen_q < len_q))
    else $error("payload index reached frame length");

  a_good_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_fire && res_kind == ubx_pkg::KindGood) |=>
      (good_q == $past(good_q) + COUNT_WIDTH'(1)))
    else $error("good counter did not advance on good frame");

  a_good_only_on_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && res_valid && res_kind == ubx_pkg::KindGood) |=>
      $stable(good_q))
    else $error("good counter moved without a good frame");
`endif

endmodule

// ===== tb/ubx_frame_deframer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ubx_frame_deframer_tb
// Self-checking bench for the frame deframer. A short directed stream
// covers the zero-length frame, a repeated first sync byte, a bad
// checksum and a length rejection. Random frames, corrupt frames,
// rejections and noise then follow under several length limits. Every
// accepted byte runs through a predictor of the deframer, and each result
// word is compared in order with the predicted words, or with the word that a directed byte carries.
// ----------------------------------------------------------------------------
module ubx_frame_deframer_tb;

  localparam int WatchdogLimit = 2000;
  localparam int PhaseBytes    = 80;
  localparam int NumPhases     = 6;

  typedef struct {
    logic [7:0]       rx;
    bit               typed;
    ubx_pkg::result_t word;
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  msg_class_o;
  logic [7:0]  msg_id_o;
  logic [15:0] frame_len_o;
  logic [7:0]  payload_byte_o;
  logic [15:0] byte_index_o;
  logic [15:0] good_count_o;
  logic [15:0] bad_sum_count_o;
  logic [15:0] resync_count_o;

  ubx_frame_deframer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .msg_class_o     (msg_class_o),
    .msg_id_o        (msg_id_o),
    .frame_len_o     (frame_len_o),
    .payload_byte_o  (payload_byte_o),
    .byte_index_o    (byte_index_o),
    .good_count_o    (good_count_o),
    .bad_sum_count_o (bad_sum_count_o),
    .resync_count_o  (resync_count_o)
  );

  always #6 clk_i = ~clk_i;

  // deframer predictor state
  logic [3:0]  df_phase = ubx_pkg::PhHunt1;
  logic [7:0]  df_class = '0;
  logic [7:0]  df_id = '0;
  logic [15:0] df_len = '0;
  logic [15:0] df_seen = '0;
  logic [15:0] df_sums = '0;  // {sum b, sum a}
  logic [7:0]  df_ck_a = '0;
  logic        df_skipped = 1'b0;
  logic [15:0] df_good = '0;
  logic [15:0] df_bad = '0;
  logic [15:0] df_resync = '0;
  logic [15:0] df_limit = ubx_pkg::LenLimitReset;

  stim_t            stim_q[$];
  ubx_pkg::result_t pending_words[$];
  logic [7:0]       last_pushed = '0;
  logic [15:0]      limit_plan [NumPhases];

  // travels with the byte on the input lane, sampled at acceptance
  bit               lane_typed = 1'b0;
  ubx_pkg::result_t lane_word = '0;

  bit               hold_req = 1'b0;
  bit               mon_emit;
  ubx_pkg::result_t mon_word;
  ubx_pkg::result_t got_word;
  ubx_pkg::result_t want_word;
  int               fails = 0;
  int               bytes_in = 0;
  int               words_checked = 0;
  int               kind_seen [4] = '{0, 0, 0, 0};
  int               idle_cycles = 0;

  function automatic logic [15:0] fletcher_step(logic [15:0] sums, logic [7:0] x);
    logic [7:0] a;
    logic [7:0] b;
    a = sums[7:0] + x;
    b = sums[15:8] + a;
    return {b, a};
  endfunction

  function automatic ubx_pkg::result_t frame_word(logic [1:0] kind, logic [7:0] pb,
                                                  logic [15:0] idx);
    ubx_pkg::result_t r;
    r = {kind, df_class, df_id, df_len, pb, idx, df_good, df_bad, df_resync};
    return r;
  endfunction

  function automatic ubx_pkg::result_t mk_word(logic [1:0] kind, logic [7:0] cls,
                                               logic [7:0] id, logic [15:0] len,
                                               logic [15:0] g, logic [15:0] b,
                                               logic [15:0] r);
    ubx_pkg::result_t w;
    w = {kind, cls, id, len, 8'h00, 16'h0000, g, b, r};
    return w;
  endfunction

  function automatic string fmt_word(ubx_pkg::result_t w);
    return $sformatf("kind %0d class %02h id %02h len %04h byte %02h idx %04h cnt %04h/%04h/%04h",
                     w.kind, w.msg_class, w.msg_id, w.frame_len, w.payload_byte, w.byte_index,
                     w.good_count, w.bad_sum_count, w.resync_count);
  endfunction

  task automatic deframe_byte(input logic [7:0] b, output bit emit, output ubx_pkg::result_t r);
    bit ok;
    emit = 1'b0;
    r = '0;
    case (df_phase)
      ubx_pkg::PhHunt2: begin
        if (b == ubx_pkg::SyncTwo) begin
          if (df_skipped) df_resync = df_resync + 16'd1;
          df_skipped = 1'b0;
          df_phase = ubx_pkg::PhClass;
        end else begin
          df_skipped = 1'b1;
          df_phase = (b == ubx_pkg::SyncOne) ? ubx_pkg::PhHunt2 : ubx_pkg::PhHunt1;
        end
      end
      ubx_pkg::PhClass: begin
        df_class = b;
        df_sums = fletcher_step(16'h0000, b);
        df_phase = ubx_pkg::PhId;
      end
      ubx_pkg::PhId: begin
        df_id = b;
        df_sums = fletcher_step(df_sums, b);
        df_phase = ubx_pkg::PhLenLo;
      end
      ubx_pkg::PhLenLo: begin
        df_len = {8'h00, b};
        df_sums = fletcher_step(df_sums, b);
        df_phase = ubx_pkg::PhLenHi;
      end
      ubx_pkg::PhLenHi: begin
        df_len[15:8] = b;
        df_sums = fletcher_step(df_sums, b);
        df_seen = '0;
        if (df_len > df_limit) begin
          df_resync = df_resync + 16'd1;
          df_skipped = 1'b0;
          df_phase = ubx_pkg::PhHunt1;
          emit = 1'b1;
          r = frame_word(ubx_pkg::KindRejected, 8'h00, 16'h0000);
        end else begin
          df_phase = (df_len == 16'h0000) ? ubx_pkg::PhCkA : ubx_pkg::PhPayload;
        end
      end
      ubx_pkg::PhPayload: begin
        df_sums = fletcher_step(df_sums, b);
        emit = 1'b1;
        r = frame_word(ubx_pkg::KindPayload, b, df_seen);
        df_seen = df_seen + 16'd1;
        if (df_seen >= df_len) df_phase = ubx_pkg::PhCkA;
      end
      ubx_pkg::PhCkA: begin
        df_ck_a = b;
        df_phase = ubx_pkg::PhCkB;
      end
      ubx_pkg::PhCkB: begin
        ok = (df_ck_a == df_sums[7:0]) && (b == df_sums[15:8]);
        if (ok) df_good = df_good + 16'd1;
        else df_bad = df_bad + 16'd1;
        df_skipped = 1'b0;
        df_phase = ubx_pkg::PhHunt1;
        emit = 1'b1;
        r = frame_word(ok ? ubx_pkg::KindGood : ubx_pkg::KindBadSum, 8'h00, 16'h0000);
      end
      default: begin
        // unknown codes hunt like the first sync phase
        if (b == ubx_pkg::SyncOne) begin
          df_phase = ubx_pkg::PhHunt2;
        end else begin
          df_skipped = 1'b1;
          df_phase = ubx_pkg::PhHunt1;
        end
      end
    endcase
  endtask

  task automatic push_byte(input logic [7:0] rx, input bit typed, input ubx_pkg::result_t word);
    stim_t item;
    item.rx = rx;
    item.typed = typed;
    item.word = word;
    stim_q.push_back(item);
    last_pushed = rx;
  endtask

  task automatic queue_frame(input logic [15:0] len, input bit corrupt, input bit header_only);
    logic [7:0]  hdr [4];
    logic [15:0] sums;
    logic [7:0]  pb;
    int          i;
    hdr[0] = 8'($urandom);
    hdr[1] = 8'($urandom);
    hdr[2] = len[7:0];
    hdr[3] = len[15:8];
    sums = '0;
    push_byte(ubx_pkg::SyncOne, 1'b0, '0);
    push_byte(ubx_pkg::SyncTwo, 1'b0, '0);
    for (i = 0; i < 4; i++) begin
      sums = fletcher_step(sums, hdr[i]);
      push_byte(hdr[i], 1'b0, '0);
    end
    if (!header_only) begin
      for (i = 0; i < int'(len); i++) begin
        pb = 8'($urandom);
        sums = fletcher_step(sums, pb);
        push_byte(pb, 1'b0, '0);
      end
      if (corrupt) sums = sums ^ (16'h0001 << $urandom_range(0, 15));
      push_byte(sums[7:0], 1'b0, '0);
      push_byte(sums[15:8], 1'b0, '0);
    end
  endtask

  task automatic build_phase(input logic [15:0] lim, input int nbytes);
    int          pick;
    int          cap;
    int          n;
    logic [15:0] len;
    logic [7:0]  nb;
    cap = (lim < 16'd40) ? int'(lim) : 40;
    while (stim_q.size() < nbytes) begin
      pick = $urandom_range(0, 99);
      if (pick >= 77 && pick < 87 && lim != 16'hFFFF) begin
        if ($urandom_range(0, 1) == 0) len = lim + 16'd1;
        else len = 16'($urandom_range(int'(lim) + 1, 65535));
        queue_frame(len, 1'b0, 1'b1);
      end else if (pick < 87) begin
        n = $urandom_range(0, 9);
        if (n == 0) len = 16'(cap);
        else if (n == 1) len = 16'($urandom_range(0, cap));
        else len = 16'($urandom_range(0, (cap < 6) ? cap : 6));
        queue_frame(len, (pick >= 65 && pick < 77), 1'b0);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: nb = ubx_pkg::SyncOne;
            1: nb = ubx_pkg::SyncTwo;
            default: nb = 8'($urandom);
          endcase
          // no sync pair inside noise, else a random header length follows
          if (last_pushed == ubx_pkg::SyncOne && nb == ubx_pkg::SyncTwo) nb = 8'h00;
          push_byte(nb, 1'b0, '0);
        end
      end
    end
  endtask

  task automatic send_bytes();
    stim_t item;
    int    burst;
    int    gap;
    while (stim_q.size() > 0) begin
      burst = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      while (burst > 0 && stim_q.size() > 0) begin
        item = stim_q.pop_front();
        in_valid_i <= 1'b1;
        rx_byte_i <= item.rx;
        lane_typed <= item.typed;
        lane_word <= item.word;
        do @(posedge clk_i); while (!in_ready_o);
        burst--;
      end
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic write_limit(input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // receiver: rotating stall pattern, plus one long hold on request
  initial begin
    logic [15:0] stall_pat;
    int          pat_left;
    int          hold_left;
    stall_pat = '0;
    pat_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (pat_left == 0) begin
        pat_left = $urandom_range(16, 80);
        stall_pat = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
        stall_pat[$urandom_range(0, 15)] = 1'b0;
      end
      pat_left--;
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ~stall_pat[0];
      end
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  // prediction on each accepted byte, checking on each accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) df_limit = cfg_data_i;
      if (in_valid_i && in_ready_o) begin
        deframe_byte(rx_byte_i, mon_emit, mon_word);
        if (lane_typed) pending_words.push_back(lane_word);
        else if (mon_emit) pending_words.push_back(mon_word);
        bytes_in++;
      end
      if (out_valid_o && out_ready_i) begin
        got_word = {kind_o, msg_class_o, msg_id_o, frame_len_o, payload_byte_o, byte_index_o,
                    good_count_o, bad_sum_count_o, resync_count_o};
        if (pending_words.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected word: %s", fmt_word(got_word));
        end else begin
          want_word = pending_words.pop_front();
          if (got_word !== want_word) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: expected %s", fmt_word(want_word));
              $display("          actual   %s", fmt_word(got_word));
            end
          end
          words_checked++;
          kind_seen[got_word.kind]++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no word moved for %0d cycles", WatchdogLimit);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero-length frame, all-zero header and checksum, reset limit
    push_byte(ubx_pkg::SyncOne, 1'b0, '0);
    push_byte(ubx_pkg::SyncTwo, 1'b0, '0);
    repeat (5) push_byte(8'h00, 1'b0, '0);
    push_byte(8'h00, 1'b1, mk_word(ubx_pkg::KindGood, 8'h00, 8'h00, 16'h0000,
                                   16'd1, 16'd0, 16'd0));
    // repeated first sync byte, all-ones class and id, zero length, wrong second checksum byte
    push_byte(ubx_pkg::SyncOne, 1'b0, '0);
    push_byte(ubx_pkg::SyncOne, 1'b0, '0);
    push_byte(ubx_pkg::SyncTwo, 1'b0, '0);
    push_byte(8'hFF, 1'b0, '0);
    push_byte(8'hFF, 1'b0, '0);
    push_byte(8'h00, 1'b0, '0);
    push_byte(8'h00, 1'b0, '0);
    push_byte(8'hFE, 1'b0, '0);
    push_byte(8'h00, 1'b1, mk_word(ubx_pkg::KindBadSum, 8'hFF, 8'hFF, 16'h0000,
                                   16'd1, 16'd1, 16'd1));
    // largest length, above the reset limit
    push_byte(ubx_pkg::SyncOne, 1'b0, '0);
    push_byte(ubx_pkg::SyncTwo, 1'b0, '0);
    push_byte(8'h01, 1'b0, '0);
    push_byte(8'h02, 1'b0, '0);
    push_byte(8'hFF, 1'b0, '0);
    push_byte(8'hFF, 1'b1, mk_word(ubx_pkg::KindRejected, 8'h01, 8'h02, 16'hFFFF,
                                   16'd1, 16'd1, 16'd2));
    // one payload byte
    queue_frame(16'd1, 1'b0, 1'b0);
    send_bytes();
    wait_idle();

    limit_plan[0] = 16'd0;
    limit_plan[1] = 16'hFFFF;
    limit_plan[2] = 16'd3;
    limit_plan[3] = 16'd40;
    limit_plan[4] = 16'($urandom);
    limit_plan[5] = ubx_pkg::LenLimitReset;
    for (int p = 0; p < NumPhases; p++) begin
      write_limit(limit_plan[p]);
      // long receiver hold while bytes keep coming
      if (p == 3) hold_req = 1'b1;
      build_phase(limit_plan[p], PhaseBytes);
      send_bytes();
      wait_idle();
    end
    repeat (8) @(posedge clk_i);

    if (pending_words.size() != 0) begin
      $display("%0d expected words never arrived", pending_words.size());
      fails++;
    end
    $display("tb: %0d bytes in, %0d words checked, %0d limit settings plus reset value",
             bytes_in, words_checked, NumPhases);
    $display("tb: payload %0d, good %0d, bad sum %0d, rejected %0d, mismatches %0d",
             kind_seen[ubx_pkg::KindPayload], kind_seen[ubx_pkg::KindGood],
             kind_seen[ubx_pkg::KindBadSum], kind_seen[ubx_pkg::KindRejected], fails);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== ubx_frame_deframer.f =====
rtl/ubx_pkg.sv
rtl/ubx_frame_deframer.sv
tb/ubx_frame_deframer_tb.sv
